// ===== src/first_fit_block_pool_allocator_unit_defines.svh =====
// assertion helpers for the bound checker
`ifndef FIRST_FIT_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// property checked outside reset
`define FFBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that also covers reset cycles
`define FFBP_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ffbp_pkg.sv =====
package ffbp_pkg;

    localparam int MAX_BLOCKS    = 16;
    localparam int BLOCK_INDEX_W = 4;
    localparam int SIZE_W        = 32;
    localparam int CAP_W         = 33;

    localparam logic [CAP_W-1:0]  ALIGN_BYTES       = CAP_W'(1024 * 1024);
    localparam logic [SIZE_W-1:0] DEFAULT_BLOCK_RST = SIZE_W'(67108864);

    typedef enum logic [1:0] {
        ST_FIT   = 2'd0,
        ST_NEW   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RESET = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_RESET = 1'b1
    } t_op;

    // request token walking down the cell chain
    typedef struct packed {
        logic                     live;
        logic                     done;
        logic [SIZE_W-1:0]        size;
        logic [CAP_W-1:0]         cap;
        t_status                  status;
        logic [BLOCK_INDEX_W-1:0] index;
        logic [CAP_W-1:0]         offset;
    } t_token;

endpackage

// ===== src/ffbp_cell.sv =====
module ffbp_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_clear,
    input  logic [ffbp_pkg::BLOCK_INDEX_W-1:0]  i_index,
    input  ffbp_pkg::t_token                    i_tok,
    output ffbp_pkg::t_token                    o_tok
);

    logic                         r_open;
    logic                         n_open;
    logic [ffbp_pkg::CAP_W-1:0]   r_cap;
    logic [ffbp_pkg::CAP_W-1:0]   n_cap;
    logic [ffbp_pkg::CAP_W-1:0]   r_used;
    logic [ffbp_pkg::CAP_W-1:0]   n_used;
    ffbp_pkg::t_token             r_tok;
    ffbp_pkg::t_token             n_tok;
    logic [ffbp_pkg::CAP_W-1:0]   w_free;
    logic                         w_fits;

    always_comb begin
        w_free = (r_cap >= r_used) ? (r_cap - r_used) : '0;
        w_fits = r_open && (w_free >= ffbp_pkg::CAP_W'(i_tok.size));
    end

    always_comb begin
        n_open = r_open;
        n_cap  = r_cap;
        n_used = r_used;
        n_tok  = i_tok;
        if (i_tok.live && !i_tok.done) begin
            if (r_open) begin
                if (w_fits) begin
                    n_used       = r_used + ffbp_pkg::CAP_W'(i_tok.size);
                    n_tok.done   = 1'b1;
                    n_tok.status = ffbp_pkg::ST_FIT;
                    n_tok.index  = i_index;
                    n_tok.offset = r_used;
                end
            end else begin
                // open blocks form a prefix, so the first closed cell is the next block
                n_open       = 1'b1;
                n_cap        = i_tok.cap;
                n_used       = ffbp_pkg::CAP_W'(i_tok.size);
                n_tok.done   = 1'b1;
                n_tok.status = ffbp_pkg::ST_NEW;
                n_tok.index  = i_index;
                n_tok.offset = '0;
            end
        end
        if (i_clear) begin
            n_open = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_tok  <= '0;
        end else begin
            r_open <= n_open;
            r_tok  <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap  <= n_cap;
        r_used <= n_used;
    end

    assign o_tok = r_tok;

endmodule

// ===== src/first_fit_block_pool_allocator_unit.sv =====
// First-fit pool allocator over a chain of block cells, one cell per block.
// Input channel: i_valid / o_stall with i_op and i_request_bytes. A transfer
// happens at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_status, o_block_index, o_offset.
// Configuration: i_cfg_wr_en / i_cfg_wr_data write the default block size.
// An allocate request walks the chain one cell per cycle; the first open
// cell with room takes it, else the first closed cell opens a new block.
// An allocate passes the launch register, then each cell register in turn,
// before its result reaches o_valid; a pool reset request answers in the
// next cycle and clears every cell. One item is in flight at a time: o_stall
// stays high from an input transfer until its result has left the output
// register, so a new request is taken only once the last one is through; the
// wait for an allocate is set by the length of the cell chain.
// While the receiver holds i_stall the result waits in the output register
// and no new item is taken.
// Reset (i_rst_n low, synchronous) empties the pool, drops any request in
// flight and restores the default block size to 64 MiB.
module first_fit_block_pool_allocator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_op,
    input  logic [ffbp_pkg::SIZE_W-1:0]         i_request_bytes,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_status,
    output logic [ffbp_pkg::BLOCK_INDEX_W-1:0]  o_block_index,
    output logic [ffbp_pkg::CAP_W-1:0]          o_offset,
    input  logic                                i_cfg_wr_en,
    input  logic [ffbp_pkg::SIZE_W-1:0]         i_cfg_wr_data
);

    logic [ffbp_pkg::SIZE_W-1:0]        r_default_bytes;
    logic                               r_busy;
    logic                               n_busy;
    ffbp_pkg::t_token                   r_launch;
    ffbp_pkg::t_token                   n_launch;
    logic                               r_out_valid;
    logic                               n_out_valid;
    ffbp_pkg::t_status                  r_out_status;
    ffbp_pkg::t_status                  n_out_status;
    logic [ffbp_pkg::BLOCK_INDEX_W-1:0] r_out_index;
    logic [ffbp_pkg::BLOCK_INDEX_W-1:0] n_out_index;
    logic [ffbp_pkg::CAP_W-1:0]         r_out_offset;
    logic [ffbp_pkg::CAP_W-1:0]         n_out_offset;

    logic                               w_accept;
    logic                               w_clear;
    logic [ffbp_pkg::SIZE_W-1:0]        w_min_bytes;
    logic [ffbp_pkg::CAP_W-1:0]         w_cap;
    ffbp_pkg::t_token                   w_tok [ffbp_pkg::MAX_BLOCKS+1];
    ffbp_pkg::t_token                   w_tail;

    assign o_stall  = r_busy || r_out_valid;
    assign w_accept = i_valid && !o_stall;
    assign w_clear  = w_accept && (i_op == ffbp_pkg::OP_RESET);

    // capacity of a block opened for this request, a multiple of 1 MiB
    always_comb begin
        w_min_bytes = (i_request_bytes > r_default_bytes) ? i_request_bytes : r_default_bytes;
        w_cap = (ffbp_pkg::CAP_W'(w_min_bytes) + (ffbp_pkg::ALIGN_BYTES - 1'b1))
              & ~(ffbp_pkg::ALIGN_BYTES - 1'b1);
    end

    assign w_tok[0] = r_launch;

    for (genvar g = 0; g < ffbp_pkg::MAX_BLOCKS; g++) begin : g_cell
        ffbp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_clear),
            .i_index (ffbp_pkg::BLOCK_INDEX_W'(g)),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_tail = w_tok[ffbp_pkg::MAX_BLOCKS];

    always_comb begin
        n_launch        = '0;
        n_busy          = r_busy;
        n_out_valid     = r_out_valid && i_stall;
        n_out_status    = r_out_status;
        n_out_index     = r_out_index;
        n_out_offset    = r_out_offset;
        if (w_accept) begin
            if (i_op == ffbp_pkg::OP_RESET) begin
                n_out_valid  = 1'b1;
                n_out_status = ffbp_pkg::ST_RESET;
                n_out_index  = '0;
                n_out_offset = '0;
            end else begin
                n_busy          = 1'b1;
                n_launch.live   = 1'b1;
                n_launch.size   = i_request_bytes;
                n_launch.cap    = w_cap;
                n_launch.status = ffbp_pkg::ST_FIT;
            end
        end
        if (w_tail.live) begin
            n_busy      = 1'b0;
            n_out_valid = 1'b1;
            if (w_tail.done) begin
                n_out_status = w_tail.status;
                n_out_index  = w_tail.index;
                n_out_offset = w_tail.offset;
            end else begin
                // ran past the last cell: table full
                n_out_status = ffbp_pkg::ST_FULL;
                n_out_index  = '0;
                n_out_offset = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_bytes <= ffbp_pkg::DEFAULT_BLOCK_RST;
            r_busy          <= 1'b0;
            r_launch        <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_default_bytes <= i_cfg_wr_data;
            end
            r_busy      <= n_busy;
            r_launch    <= n_launch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_offset <= n_out_offset;
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_block_index = r_out_index;
    assign o_offset      = r_out_offset;

endmodule

// ===== src/ffbp_checker.sv =====
`include "first_fit_block_pool_allocator_unit_defines.svh"

module ffbp_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_stall,
    input  logic                                i_op,
    input  logic [ffbp_pkg::SIZE_W-1:0]         i_request_bytes,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic [1:0]                          o_status,
    input  logic [ffbp_pkg::BLOCK_INDEX_W-1:0]  o_block_index,
    input  logic [ffbp_pkg::CAP_W-1:0]          o_offset,
    input  logic                                i_cfg_wr_en,
    input  logic [ffbp_pkg::SIZE_W-1:0]         i_cfg_wr_data
);

    // a stalled result holds
    `FFBP_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_offset), "result changed while stalled")

    // one item in flight: a transfer closes the input side
    `FFBP_ASSERT(a_one_in_flight, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall, "input taken while an item is in flight")

    // table full and reset results carry no placement
    `FFBP_ASSERT(a_no_place, i_clk, i_rst_n, o_valid && (o_status == ffbp_pkg::ST_FULL || o_status == ffbp_pkg::ST_RESET) |-> o_offset == '0 && o_block_index == '0, "failure or reset result has a placement")

    // a new block holds the request at its start
    `FFBP_ASSERT(a_new_at_zero, i_clk, i_rst_n, o_valid && o_status == ffbp_pkg::ST_NEW |-> o_offset == '0, "new block result not at offset zero")

    // reset drops any pending result
    `FFBP_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall, "output not empty after reset")

endmodule

bind first_fit_block_pool_allocator_unit ffbp_checker u_ffbp_checker (.*);

// ===== tb/first_fit_block_pool_allocator_unit_checker.sv =====
`timescale 1ns / 100ps
module first_fit_block_pool_allocator_unit_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_stall,
    input  logic                               i_in_op,
    input  logic [ffbp_pkg::SIZE_W-1:0]        i_in_bytes,
    input  logic                               i_out_valid,
    input  logic                               i_out_stall,
    input  logic [1:0]                         i_out_status,
    input  logic [ffbp_pkg::BLOCK_INDEX_W-1:0] i_out_index,
    input  logic [ffbp_pkg::CAP_W-1:0]         i_out_offset,
    input  logic                               i_cfg_wr_en,
    input  logic [ffbp_pkg::SIZE_W-1:0]        i_cfg_wr_data,
    output int                                 o_fail_count,
    output int                                 o_outstanding,
    output int                                 o_results,
    output int                                 o_full_hits
);

    localparam int GRANT_DEPTH = 16;

    typedef struct {
        ffbp_pkg::t_status                  status;
        logic [ffbp_pkg::BLOCK_INDEX_W-1:0] index;
        logic [ffbp_pkg::CAP_W-1:0]         offset;
    } t_grant;

    t_grant                       expected_grants [GRANT_DEPTH];
    int                           wr_ptr = 0;
    int                           rd_ptr = 0;
    int                           pending = 0;
    logic [ffbp_pkg::SIZE_W-1:0]  min_block_bytes = ffbp_pkg::DEFAULT_BLOCK_RST;
    int                           open_count = 0;
    logic [ffbp_pkg::CAP_W-1:0]   capacity [ffbp_pkg::MAX_BLOCKS];
    logic [ffbp_pkg::CAP_W-1:0]   used [ffbp_pkg::MAX_BLOCKS];
    int                           mismatches = 0;
    int                           checked = 0;
    int                           full_hits = 0;

    function automatic t_grant predict_allocation(input logic op,
                                                  input logic [ffbp_pkg::SIZE_W-1:0] bytes);
        t_grant                     g;
        logic [ffbp_pkg::CAP_W-1:0] req;
        logic [ffbp_pkg::CAP_W-1:0] room;
        logic [ffbp_pkg::CAP_W-1:0] new_cap;
        g = '{ffbp_pkg::ST_RESET, '0, '0};
        if (op == ffbp_pkg::OP_RESET) begin
            open_count = 0;
            return g;
        end
        req = ffbp_pkg::CAP_W'(bytes);
        // first fit, oldest block first
        for (int b = 0; b < open_count; b++) begin
            room = (capacity[b] >= used[b]) ? capacity[b] - used[b] : '0;
            if (room >= req) begin
                g.status = ffbp_pkg::ST_FIT;
                g.index  = ffbp_pkg::BLOCK_INDEX_W'(b);
                g.offset = used[b];
                used[b]  = used[b] + req;
                return g;
            end
        end
        g.status = ffbp_pkg::ST_FULL;
        if (open_count >= ffbp_pkg::MAX_BLOCKS)
            return g;
        new_cap = ffbp_pkg::CAP_W'(min_block_bytes);
        if (req > new_cap)
            new_cap = req;
        new_cap = (new_cap + ffbp_pkg::ALIGN_BYTES - ffbp_pkg::CAP_W'(1))
                & ~(ffbp_pkg::ALIGN_BYTES - ffbp_pkg::CAP_W'(1));
        capacity[open_count] = new_cap;
        used[open_count]     = req;
        g.status = ffbp_pkg::ST_NEW;
        g.index  = ffbp_pkg::BLOCK_INDEX_W'(open_count);
        open_count++;
        return g;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_grant want;
        if (!i_rst_n) begin
            min_block_bytes = ffbp_pkg::DEFAULT_BLOCK_RST;
            open_count      = 0;
            wr_ptr          = 0;
            rd_ptr          = 0;
            pending         = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending == 0) begin
                    $error("result transfer with nothing expected: status %0d index %0d offset %0h",
                           i_out_status, i_out_index, i_out_offset);
                    mismatches++;
                end else begin
                    want   = expected_grants[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % GRANT_DEPTH;
                    pending--;
                    checked++;
                    if (want.status == ffbp_pkg::ST_FULL)
                        full_hits++;
                    if (i_out_status != want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_out_status);
                        mismatches++;
                    end
                    if (i_out_index != want.index) begin
                        $error("block_index: expected %0d, actual %0d", want.index, i_out_index);
                        mismatches++;
                    end
                    if (i_out_offset != want.offset) begin
                        $error("offset: expected %0h, actual %0h", want.offset, i_out_offset);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_wr_en)
                min_block_bytes = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) begin
                if (pending == GRANT_DEPTH) begin
                    $error("too many transfers waiting for a result");
                    mismatches++;
                end else begin
                    expected_grants[wr_ptr] = predict_allocation(i_in_op, i_in_bytes);
                    wr_ptr = (wr_ptr + 1) % GRANT_DEPTH;
                    pending++;
                end
            end
        end
        o_outstanding <= pending;
        o_fail_count  <= mismatches;
        o_results     <= checked;
        o_full_hits   <= full_hits;
    end

endmodule

// ===== tb/first_fit_block_pool_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
module first_fit_block_pool_allocator_unit_tb;

    localparam int CYCLE_LIMIT     = 600000;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int TAIL_CYCLES     = 2 * ffbp_pkg::MAX_BLOCKS + 8;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic                               i_op = 1'b0;
    logic [ffbp_pkg::SIZE_W-1:0]        i_request_bytes = '0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic [1:0]                         o_status;
    logic [ffbp_pkg::BLOCK_INDEX_W-1:0] o_block_index;
    logic [ffbp_pkg::CAP_W-1:0]         o_offset;
    logic                               i_cfg_wr_en = 1'b0;
    logic [ffbp_pkg::SIZE_W-1:0]        i_cfg_wr_data = '0;

    int   fail_count;
    int   outstanding;
    int   results;
    int   full_hits;
    int   cycles = 0;
    int   items_sent = 0;
    int   resets_sent = 0;
    int   settings = 0;
    int   rx_hold = 0;
    logic rx_calm = 1'b0;
    logic tx_calm = 1'b0;

    first_fit_block_pool_allocator_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_request_bytes (i_request_bytes),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_block_index   (o_block_index),
        .o_offset        (o_offset),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    first_fit_block_pool_allocator_unit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_op       (i_op),
        .i_in_bytes    (i_request_bytes),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_out_status  (o_status),
        .i_out_index   (o_block_index),
        .i_out_offset  (o_offset),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_results     (results),
        .o_full_hits   (full_hits)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver back-pressure: mostly short holds, now and then a long one
    always @(posedge i_clk) begin : rx_side
        int r;
        r = $urandom_range(0, 99);
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_stall <= 1'b1;
        end else if (rx_calm || r < 60) begin
            i_stall <= 1'b0;
        end else if (r < 95) begin
            rx_hold <= $urandom_range(0, 3);
            i_stall <= 1'b1;
        end else begin
            rx_hold <= $urandom_range(10, 40);
            i_stall <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [ffbp_pkg::SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 35)
            return ffbp_pkg::SIZE_W'($urandom_range(1, 4096));
        if (r < 55)
            return ffbp_pkg::SIZE_W'($urandom_range(1, 64)) << 20;
        if (r < 65)
            return (ffbp_pkg::SIZE_W'($urandom_range(1, 64)) << 20)
                 + ffbp_pkg::SIZE_W'($urandom_range(0, 2)) - ffbp_pkg::SIZE_W'(1);
        if (r < 75)
            return 32'hFFFF_FFFF - ffbp_pkg::SIZE_W'($urandom_range(0, 3));
        if (r < 90)
            return ffbp_pkg::SIZE_W'($urandom);
        return ffbp_pkg::SIZE_W'($urandom_range(0, 32'h0800_0000));
    endfunction

    task automatic send_item(input ffbp_pkg::t_op op,
                             input logic [ffbp_pkg::SIZE_W-1:0] bytes);
        int gap;
        i_valid         <= 1'b1;
        i_op            <= op;
        i_request_bytes <= bytes;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        items_sent++;
        if (op == ffbp_pkg::OP_RESET)
            resets_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_min_block(input logic [ffbp_pkg::SIZE_W-1:0] bytes);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= bytes;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        settings++;
    endtask

    task automatic random_phase(input int count);
        ffbp_pkg::t_op op;
        for (int n = 0; n < count; n++) begin
            if (n % 60 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm <= ($urandom_range(0, 3) == 0);
            end
            op = ($urandom_range(0, 99) < 4) ? ffbp_pkg::OP_RESET : ffbp_pkg::OP_ALLOC;
            send_item(op, pick_size());
        end
    endtask

    initial begin : stimulus
        logic [ffbp_pkg::SIZE_W-1:0] setting_list [5];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default block size from reset
        send_item(ffbp_pkg::OP_ALLOC, '0);            // zero bytes with empty pool
        send_item(ffbp_pkg::OP_ALLOC, '0);            // zero bytes fits block 0
        send_item(ffbp_pkg::OP_ALLOC, 32'h0400_0000); // exact fill of block 0
        send_item(ffbp_pkg::OP_ALLOC, '0);            // zero bytes into a full block
        send_item(ffbp_pkg::OP_ALLOC, 32'h0000_0001);
        send_item(ffbp_pkg::OP_ALLOC, 32'hFFFF_FFFF); // capacity rounds up to 4 GiB
        send_item(ffbp_pkg::OP_ALLOC, 32'h0000_0001);
        send_item(ffbp_pkg::OP_RESET, 32'hFFFF_FFFF);
        // open every block, then overflow the table
        for (int n = 0; n <= ffbp_pkg::MAX_BLOCKS; n++)
            send_item(ffbp_pkg::OP_ALLOC, 32'hFFFF_FFFF);
        send_item(ffbp_pkg::OP_RESET, '0);
        drain();

        // smallest block size: capacity becomes exactly 1 MiB
        write_min_block(32'h0000_0001);
        send_item(ffbp_pkg::OP_ALLOC, 32'h0000_0001);
        send_item(ffbp_pkg::OP_ALLOC, 32'h000F_FFFF); // exact fit of the remainder
        send_item(ffbp_pkg::OP_ALLOC, 32'h0000_0001);
        send_item(ffbp_pkg::OP_ALLOC, '0);
        random_phase(ITEMS_PER_PHASE);
        drain();

        setting_list[0] = 32'hFFFF_FFFF;
        setting_list[1] = 32'h0010_0000;
        setting_list[2] = 32'h0010_0001;
        setting_list[3] = ffbp_pkg::SIZE_W'($urandom);
        setting_list[4] = ffbp_pkg::DEFAULT_BLOCK_RST;
        if (setting_list[3] == '0)
            setting_list[3] = 32'h0000_0001;
        foreach (setting_list[s]) begin
            write_min_block(setting_list[s]);
            send_item(ffbp_pkg::OP_RESET, ffbp_pkg::SIZE_W'($urandom));
            random_phase(ITEMS_PER_PHASE);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d requests (%0d pool resets) over %0d block-size settings",
                 items_sent, resets_sent, settings);
        $display("%0d results compared, %0d of them table-full answers", results, full_hits);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/ffbp_pkg.sv
src/ffbp_cell.sv
src/first_fit_block_pool_allocator_unit.sv
src/ffbp_checker.sv
tb/first_fit_block_pool_allocator_unit_checker.sv
tb/first_fit_block_pool_allocator_unit_tb.sv
